// File: hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the two-level page table engine
// Entry layout, operation and status codes, and the update request/result
// structs passed between the controller and the update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    localparam int DIR_ENTRIES_DEF = 16;
    localparam int PAGE_SHIFT      = 12;
    localparam int PG_W            = 10;
    localparam int PAGES_PER_TABLE = 1 << PG_W;
    localparam int OFFSET_W        = 12;
    localparam int FRAME_W         = 20;
    localparam int DIR_LSB         = 22;
    localparam int ENTRY_W         = 23;

    typedef enum logic [1:0] {
        FN_MAP       = 2'd0,
        FN_REMAP     = 2'd1,
        FN_FREE      = 2'd2,
        FN_TRANSLATE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MAPPED   = 2'd1,
        ST_NO_TABLE = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // page entry as stored in memory
    typedef struct packed {
        logic               user;
        logic               writable;
        logic               present;
        logic [FRAME_W-1:0] frame;
    } t_pte;

    // everything the update logic needs for one item
    typedef struct packed {
        t_func               func;
        logic                dir_ok;
        logic                tbl_hit;
        t_pte                entry;
        logic [FRAME_W-1:0]  frame;
        logic                we;
        logic                ua;
        logic [OFFSET_W-1:0] offset;
    } t_upd_req;

    // what the update logic decides
    typedef struct packed {
        logic        wr_en;
        t_pte        wr_data;
        logic        set_table;
        logic [31:0] phys;
        t_status     status;
    } t_upd_res;

endpackage

`default_nettype wire

// File: hdl/ptw_ram.sv
// ----------------------------------------------------------------------------
// ptw_ram: page entry store
// Simple dual-port synchronous memory, one write and one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
    parameter int DEPTH = 16 * 1024,
    parameter int AW    = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire ptw_pkg::t_pte  i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output ptw_pkg::t_pte       o_rdata
);
    import ptw_pkg::*;

    t_pte r_mem [0:DEPTH-1];
    t_pte r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/ptw_update.sv
// ----------------------------------------------------------------------------
// ptw_update: per-item modify logic
// Given the operation, the directory lookup and the entry read from memory,
// decides the write-back, the directory update and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_update (
    input  wire ptw_pkg::t_upd_req i_req,
    output ptw_pkg::t_upd_res      o_res
);
    import ptw_pkg::*;

    always_comb begin
        o_res           = '0;
        o_res.status    = ST_OK;
        o_res.wr_data   = i_req.entry;
        if (!i_req.dir_ok) begin
            o_res.status = ST_RANGE;
        end else begin
            unique case (i_req.func)
                FN_MAP: begin
                    // table is created even when the entry is already there
                    o_res.set_table = 1'b1;
                    if (i_req.entry.present) begin
                        o_res.status = ST_MAPPED;
                    end else begin
                        o_res.wr_en            = 1'b1;
                        o_res.wr_data.frame    = i_req.frame;
                        o_res.wr_data.present  = 1'b1;
                        o_res.wr_data.writable = i_req.we;
                        o_res.wr_data.user     = i_req.ua;
                    end
                end
                FN_REMAP: begin
                    if (!i_req.tbl_hit) begin
                        o_res.status = ST_NO_TABLE;
                    end else begin
                        // flags kept, even on an entry that is not present
                        o_res.wr_en         = 1'b1;
                        o_res.wr_data.frame = i_req.frame;
                    end
                end
                FN_FREE: begin
                    if (!i_req.tbl_hit) begin
                        o_res.status = ST_NO_TABLE;
                    end else begin
                        o_res.wr_en   = 1'b1;
                        o_res.wr_data = '0;
                    end
                end
                FN_TRANSLATE: begin
                    if (!i_req.tbl_hit) begin
                        o_res.status = ST_NO_TABLE;
                    end else begin
                        o_res.phys = {i_req.entry.frame, i_req.offset};
                    end
                end
                default: begin
                    o_res.status = ST_OK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine: directory plus page entry store
// Channels: input items (i_in_valid/o_in_ready) carry func, virt_addr,
// phys_target, write_enable and user_access; result items
// (o_out_valid/i_out_ready) carry xlat_addr and status, one per input item.
// Each item passes through the entry read from the memory and then the modify
// and write-back; no new item is taken until the last has left the modify
// step. The result is registered in the output register at the end of the
// modify step, where it waits until the receiver takes it.
// The next item is taken while a finished result waits in the output
// register; if the receiver stalls, that next item holds in the modify step
// (its read data held) until the output register frees.
// Reset clears the directory bits at once and then sweeps the page entry
// store to zero, one entry a cycle; no item is taken during that pass. A
// table that does not exist always has all-zero entries, so creating a
// table needs no row clear.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_engine #(
    parameter int DIR_ENTRIES = ptw_pkg::DIR_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_virt_addr,
    input  wire logic [31:0] i_phys_target,
    input  wire logic        i_write_enable,
    input  wire logic        i_user_access,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_xlat_addr,
    output logic [1:0]       o_status
);
    import ptw_pkg::*;

    localparam int DW    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int AW    = DW + PG_W;
    localparam int DEPTH = DIR_ENTRIES * PAGES_PER_TABLE;
    localparam logic [10:0]   DIR_LIMIT = 11'(DIR_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]          r_clr_addr;
    logic [DIR_ENTRIES-1:0] r_tbl;

    // captured item
    t_func               r_func;
    logic [9:0]          r_dir;
    logic [AW-1:0]       r_addr;
    logic [FRAME_W-1:0]  r_frame;
    logic                r_we;
    logic                r_ua;
    logic [OFFSET_W-1:0] r_offset;

    // output register
    logic        r_out_valid;
    logic [31:0] r_phys;
    t_status     r_status;

    logic          accept;
    logic          go;
    logic          dir_ok;
    logic [DW-1:0] dir_idx;
    logic [AW-1:0] in_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_pte          mem_wdata;
    t_pte          mem_rdata;
    t_upd_req      upd_req;
    t_upd_res      upd_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign go         = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);
    assign in_addr    = {i_virt_addr[DIR_LSB +: DW], i_virt_addr[PAGE_SHIFT +: PG_W]};

    // directory lookup of the held item
    assign dir_ok  = ({1'b0, r_dir} < DIR_LIMIT);
    assign dir_idx = r_dir[DW-1:0];

    // control state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_LOOK;
            S_LOOK:  if (go) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // capture item on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= t_func'(i_func);
            r_dir    <= i_virt_addr[31:DIR_LSB];
            r_addr   <= in_addr;
            r_frame  <= i_phys_target[31:PAGE_SHIFT];
            r_we     <= i_write_enable;
            r_ua     <= i_user_access;
            r_offset <= i_virt_addr[OFFSET_W-1:0];
        end
    end

    // modify step
    always_comb begin
        upd_req.func    = r_func;
        upd_req.dir_ok  = dir_ok;
        upd_req.tbl_hit = dir_ok && r_tbl[dir_idx];
        upd_req.entry   = mem_rdata;
        upd_req.frame   = r_frame;
        upd_req.we      = r_we;
        upd_req.ua      = r_ua;
        upd_req.offset  = r_offset;
    end

    ptw_update u_update (
        .i_req (upd_req),
        .o_res (upd_res)
    );

    // directory present bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl <= '0;
        end else if (go && upd_res.set_table) begin
            r_tbl[dir_idx] <= 1'b1;
        end
    end

    // memory write: clearing sweep or write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = go && upd_res.wr_en;
            mem_waddr = r_addr;
            mem_wdata = upd_res.wr_data;
        end
    end

    ptw_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_phys   <= upd_res.phys;
            r_status <= upd_res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_xlat_addr = r_phys;
    assign o_status    = r_status;

    // checks
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("item taken while another is in flight");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory written with no item in flight");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result shown during clearing pass");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_LOOK))
        else $error("result without a modify step");

    a_phys_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_status != ST_OK)) |-> (o_xlat_addr == 32'd0))
        else $error("address returned with a failing status");

endmodule

`default_nettype wire

// File: dv/tb_two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// tb_two_level_page_table_engine: self-checking bench for the page table engine
// A short directed table covers missing tables, double maps, remap of an empty
// entry, free, translate and out-of-range directories. Random map, remap, free
// and translate items follow. An in-bench copy of the directory and entry store
// predicts each result, but pinned directed rows carry a hand-typed one instead;
// results are checked in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_level_page_table_engine;

    import ptw_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int DIRS         = DIR_ENTRIES_DEF;
    localparam int RAND_ITEMS   = 1850;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int SMOKE_ROWS   = 24;

    // one translation result as seen on the output channel
    typedef struct packed {
        logic [31:0] phys;
        t_status     status;
    } t_xlate_res;

    // one directed stimulus row; pinned rows carry a hand-typed result
    typedef struct packed {
        t_func       func;
        logic [31:0] va;
        logic [31:0] pa;
        logic        we;
        logic        ua;
        logic        pinned;
        logic [31:0] phys;
        t_status     status;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_func         = 2'd0;
    logic [31:0] i_virt_addr    = 32'd0;
    logic [31:0] i_phys_target  = 32'd0;
    logic        i_write_enable = 1'b0;
    logic        i_user_access  = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_xlat_addr;
    logic [1:0]  o_status;

    // bench copy of the directory bits and the page entry store
    logic       dir_present [DIRS];
    t_pte       pte_store [DIRS*PAGES_PER_TABLE];

    t_xlate_res pending_results [$];
    t_stim_row  smoke_rows [SMOKE_ROWS];
    int         error_count = 0;
    bit         idle_on     = 1'b1;

    two_level_page_table_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_virt_addr    (i_virt_addr),
        .i_phys_target  (i_phys_target),
        .i_write_enable (i_write_enable),
        .i_user_access  (i_user_access),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_xlat_addr    (o_xlat_addr),
        .o_status       (o_status)
    );

    // clock
    always begin
        #(CLK_PERIOD/2) i_clk = 1'b1;
        #(CLK_PERIOD/2) i_clk = 1'b0;
    end

    // random idle draw, about 38 of a hundred while idling is enabled
    function automatic bit idle_now();
        return idle_on && ($urandom_range(99) < 38);
    endfunction

    // apply one item to the bench tables and return the result it causes
    function automatic t_xlate_res walk_tables(t_func f, logic [31:0] va, logic [31:0] pa,
                                               logic we, logic ua);
        t_xlate_res res;
        int         dir;
        int         idx;
        dir        = int'(va[31:22]);
        res.phys   = '0;
        res.status = ST_OK;
        if (dir >= DIRS) begin
            res.status = ST_RANGE;
        end else begin
            idx = dir * PAGES_PER_TABLE + int'(va[21:12]);
            case (f)
                FN_MAP: begin
                    // first map into a directory slot brings up a clean table
                    if (!dir_present[dir]) begin
                        for (int p = 0; p < PAGES_PER_TABLE; p++)
                            pte_store[dir*PAGES_PER_TABLE + p] = '0;
                        dir_present[dir] = 1'b1;
                    end
                    if (pte_store[idx].present) begin
                        res.status = ST_MAPPED;
                    end else begin
                        pte_store[idx].frame    = pa[31:12];
                        pte_store[idx].present  = 1'b1;
                        pte_store[idx].writable = we;
                        pte_store[idx].user     = ua;
                    end
                end
                FN_REMAP: begin
                    if (!dir_present[dir]) res.status = ST_NO_TABLE;
                    else pte_store[idx].frame = pa[31:12];
                end
                FN_FREE: begin
                    if (!dir_present[dir]) res.status = ST_NO_TABLE;
                    else pte_store[idx] = '0;
                end
                default: begin
                    if (!dir_present[dir]) res.status = ST_NO_TABLE;
                    else res.phys = {pte_store[idx].frame, va[11:0]};
                end
            endcase
        end
        return res;
    endfunction

    // drive one item, wait for it to be taken, then queue its result
    task automatic send_item(t_func f, logic [31:0] va, logic [31:0] pa, logic we, logic ua,
                             logic pinned, t_xlate_res typed_res);
        t_xlate_res res;
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_virt_addr    <= va;
        i_phys_target  <= pa;
        i_write_enable <= we;
        i_user_access  <= ua;
        do @(posedge i_clk); while (!o_in_ready);
        res = walk_tables(f, va, pa, we, ua);
        pending_results.push_back(pinned ? typed_res : res);
    endtask

    // hold off the sender until every queued result has been seen
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result side: random stall and in-order check
    initial begin
        t_xlate_res want;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result addr=%h status=%0d",
                             $time, o_xlat_addr, o_status);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_xlat_addr !== want.phys) begin
                        $display("%0t: xlat_addr mismatch expected=%h actual=%h",
                                 $time, want.phys, o_xlat_addr);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    // stimulus
    initial begin
        t_xlate_res  typed;
        t_func       f;
        logic [9:0]  dir;
        logic [9:0]  pg;
        logic [31:0] va;
        int          pick;

        for (int d = 0; d < DIRS; d++) dir_present[d] = 1'b0;
        for (int e = 0; e < DIRS*PAGES_PER_TABLE; e++) pte_store[e] = '0;

        smoke_rows = '{
            // nothing exists after reset
            '{FN_TRANSLATE, 32'h0000_0123, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_NO_TABLE},
            '{FN_REMAP,     32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h0, ST_NO_TABLE},
            '{FN_FREE,      32'h0000_0000, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_NO_TABLE},
            // first map creates the table, second map is refused
            '{FN_MAP,       32'h0000_0000, 32'hFFFF_F123, 1'b1, 1'b1, 1'b1, 32'h0, ST_OK},
            '{FN_MAP,       32'h0000_0000, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_MAPPED},
            '{FN_TRANSLATE, 32'h0000_0FFF, 32'h0,         1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, ST_OK},
            // entry not present in an existing table translates with frame zero
            '{FN_TRANSLATE, 32'h0000_1ABC, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0000_0ABC, ST_OK},
            // remap of an empty entry still writes the frame
            '{FN_REMAP,     32'h0000_1000, 32'h1234_5678, 1'b0, 1'b0, 1'b1, 32'h0, ST_OK},
            '{FN_TRANSLATE, 32'h0000_1456, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
            '{FN_MAP,       32'h0000_1000, 32'hA5A5_A000, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
            '{FN_TRANSLATE, 32'h0000_1000, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
            // free then translate gives the bare offset
            '{FN_FREE,      32'h0000_0000, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_OK},
            '{FN_TRANSLATE, 32'h0000_0FFF, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0000_0FFF, ST_OK},
            // last directory slot, last page
            '{FN_MAP,       32'h03FF_FFFF, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_OK},
            '{FN_TRANSLATE, 32'h03FF_FFFF, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0000_0FFF, ST_OK},
            '{FN_REMAP,     32'h03FF_F000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h0, ST_OK},
            '{FN_TRANSLATE, 32'h03FF_FABC, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
            // directory index out of range
            '{FN_MAP,       32'h0400_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0, ST_RANGE},
            '{FN_REMAP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h0, ST_RANGE},
            '{FN_FREE,      32'hFFC0_0000, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_RANGE},
            '{FN_TRANSLATE, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 1'b1, 32'h0, ST_RANGE},
            // another table, flags crossed
            '{FN_MAP,       32'h0240_0000, 32'h5555_5000, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
            '{FN_MAP,       32'h0240_0000, 32'hAAAA_A000, 1'b0, 1'b1, 1'b1, 32'h0, ST_MAPPED},
            '{FN_TRANSLATE, 32'h0240_0AAA, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0, ST_OK}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (smoke_rows[r]) begin
            typed.phys   = smoke_rows[r].phys;
            typed.status = smoke_rows[r].status;
            send_item(smoke_rows[r].func, smoke_rows[r].va, smoke_rows[r].pa,
                      smoke_rows[r].we, smoke_rows[r].ua, smoke_rows[r].pinned, typed);
        end
        drain_results();

        // random items, clustered on few pages so entries get reused
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_on = !(n >= 700 && n < 1000);
            if (n % 400 == 399) drain_results();
            if ($urandom_range(99) < 8) dir = 10'($urandom_range(1023, DIRS));
            else dir = 10'($urandom_range(DIRS-1));
            if ($urandom_range(99) < 70) pg = 10'($urandom_range(7));
            else pg = 10'($urandom_range(1023));
            va   = {dir, pg, 12'($urandom)};
            pick = $urandom_range(99);
            if (pick < 30) f = FN_MAP;
            else if (pick < 45) f = FN_REMAP;
            else if (pick < 60) f = FN_FREE;
            else f = FN_TRANSLATE;
            send_item(f, va, $urandom, 1'($urandom), 1'($urandom), 1'b0, typed);
        end
        idle_on = 1'b1;

        // wind down
        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
